// ----- rtl/lcim_pkg.sv -----
package lcim_pkg;

	// parameter defaults
	localparam int MAX_EXTENT_DEF = 64;
	localparam int MAX_COLORS_DEF = 8;

	// field widths
	localparam int EXT_CFG_W  = 7;
	localparam int COL_CFG_W  = 4;
	localparam int MODE_W     = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;
	localparam int COORD_W    = 6;
	localparam int DIR_W      = 2;
	localparam int ROW_W      = 3;
	localparam int SITE_W     = 24;
	localparam int LINK_W     = 26;
	localparam int COMP_W     = 9;
	localparam int PHASE_W    = 4;

	// working width of site arithmetic: one bit above the link field for the final halving
	localparam int WK_W  = LINK_W + 1;
	// working width of component arithmetic
	localparam int CMP_W = COMP_W + 1;

	// layout modes
	localparam logic [MODE_W-1:0] MODE_WILSON_GAUGE = 3'd0;
	localparam logic [MODE_W-1:0] MODE_HEATBATH     = 3'd1;
	localparam logic [MODE_W-1:0] MODE_STAG_BLOCK   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_WILSON_FERM  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_STAG_FERM    = 3'd4;
	localparam logic [MODE_W-1:0] MODE_STAG_GAUGE   = 3'd5;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_T    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COLORS    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LAYOUT    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HALF      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ALT_PHASE = 3'd7;

	// reset values
	localparam logic [EXT_CFG_W-1:0] RST_EXTENT = 7'd4;
	localparam logic [COL_CFG_W-1:0] RST_COLORS = 4'd3;

	typedef struct packed {
		logic [EXT_CFG_W-1:0] size_x;
		logic [EXT_CFG_W-1:0] size_y;
		logic [EXT_CFG_W-1:0] size_z;
		logic [EXT_CFG_W-1:0] size_t;
		logic [COL_CFG_W-1:0] colors;
		logic [MODE_W-1:0]    layout_mode;
		logic                 half_lattice;
		logic                 alt_phase_convention;
	} cfg_t;

endpackage

// ----- rtl/lcim_cfg.sv -----
module lcim_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lcim_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lcim_pkg::CFG_DATA_W-1:0] cfg_data,
	output lcim_pkg::cfg_t                 cfg
);
	import lcim_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.size_x               <= RST_EXTENT;
			cfg_q.size_y               <= RST_EXTENT;
			cfg_q.size_z               <= RST_EXTENT;
			cfg_q.size_t               <= RST_EXTENT;
			cfg_q.colors               <= RST_COLORS;
			cfg_q.layout_mode          <= MODE_WILSON_GAUGE;
			cfg_q.half_lattice         <= 1'b0;
			cfg_q.alt_phase_convention <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SIZE_X:    cfg_q.size_x <= cfg_data[EXT_CFG_W-1:0];
				REG_SIZE_Y:    cfg_q.size_y <= cfg_data[EXT_CFG_W-1:0];
				REG_SIZE_Z:    cfg_q.size_z <= cfg_data[EXT_CFG_W-1:0];
				REG_SIZE_T:    cfg_q.size_t <= cfg_data[EXT_CFG_W-1:0];
				REG_COLORS:    cfg_q.colors <= cfg_data[COL_CFG_W-1:0];
				REG_LAYOUT:    cfg_q.layout_mode <= cfg_data[MODE_W-1:0];
				REG_HALF:      cfg_q.half_lattice <= cfg_data[0];
				REG_ALT_PHASE: cfg_q.alt_phase_convention <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/lattice_checkerboard_index_map.sv -----
// an input transfer passes the stage 1, 2 and 3 registers and then the output registers
// throughput: one item per cycle while the output does not stall; stages one to three each hold several multiplies
// a stalled output fills bubbles upstream before the input stalls
// reset: pipeline valid bits clear, extents 4, colors 3, other config registers 0
module lattice_checkerboard_index_map #(
	parameter int MAX_EXTENT = lcim_pkg::MAX_EXTENT_DEF,
	parameter int MAX_COLORS = lcim_pkg::MAX_COLORS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lcim_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lcim_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [lcim_pkg::COORD_W-1:0]    coord_x,
	input  logic [lcim_pkg::COORD_W-1:0]    coord_y,
	input  logic [lcim_pkg::COORD_W-1:0]    coord_z,
	input  logic [lcim_pkg::COORD_W-1:0]    coord_t,
	input  logic [lcim_pkg::DIR_W-1:0]      direction,
	input  logic [lcim_pkg::ROW_W-1:0]      mat_row,
	input  logic [lcim_pkg::ROW_W-1:0]      mat_col,
	input  logic                           imag_part,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [lcim_pkg::SITE_W-1:0]     dest_site,
	output logic [lcim_pkg::LINK_W-1:0]     dest_link,
	output logic [lcim_pkg::COMP_W-1:0]     dest_component,
	output logic [lcim_pkg::PHASE_W-1:0]    phase_bits,
	output logic                           site_absent,
	output logic                           no_move
);
	import lcim_pkg::*;

	localparam int EW = $clog2(MAX_EXTENT + 1);
	localparam int CW = $clog2(MAX_COLORS + 1);

	cfg_t cfg;

	lcim_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// saturated extents and colors
	logic [EW-1:0] lx, ly, lz, lt;
	logic [CW-1:0] nc;

	assign lx = (int'(cfg.size_x) > MAX_EXTENT) ? EW'(MAX_EXTENT) : EW'(cfg.size_x);
	assign ly = (int'(cfg.size_y) > MAX_EXTENT) ? EW'(MAX_EXTENT) : EW'(cfg.size_y);
	assign lz = (int'(cfg.size_z) > MAX_EXTENT) ? EW'(MAX_EXTENT) : EW'(cfg.size_z);
	assign lt = (int'(cfg.size_t) > MAX_EXTENT) ? EW'(MAX_EXTENT) : EW'(cfg.size_t);
	assign nc = (int'(cfg.colors) > MAX_COLORS) ? CW'(MAX_COLORS) : CW'(cfg.colors);

	// pipeline flow control: a stage loads when empty or when the next one moves
	logic v1_s1, v2_s2, v3_s3;
	logic rdy1, rdy2, rdy3, rdy4;

	assign rdy4     = !out_valid || !out_stall;
	assign rdy3     = !v3_s3 || rdy4;
	assign rdy2     = !v2_s2 || rdy3;
	assign rdy1     = !v1_s1 || rdy2;
	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1     <= 1'b0;
			v2_s2     <= 1'b0;
			v3_s3     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (rdy1) v1_s1 <= in_valid;
			if (rdy2) v2_s2 <= v1_s1;
			if (rdy3) v3_s3 <= v2_s2;
			if (rdy4) out_valid <= v3_s3;
		end
	end

	// stage 1: innermost horner terms, parity, phases, component seeds
	logic                 par_c;
	logic                 is_stag_phase;
	logic [PHASE_W-1:0]   phase_c;
	logic [DIR_W-1:0]     mu_next;
	logic [WK_W-1:0]      a1_c, b1_c, h1_c;
	logic [2*EW-1:0]      vxy_c, vzt_c;
	logic [CMP_W-1:0]     ca1_c, cd1_c;

	assign par_c   = coord_x[0] ^ coord_y[0] ^ coord_z[0] ^ coord_t[0];
	assign mu_next = direction + 2'd1;
	assign is_stag_phase = (cfg.layout_mode == MODE_STAG_BLOCK)
		|| (cfg.layout_mode == MODE_STAG_GAUGE);

	always_comb begin
		phase_c = '0;
		if (is_stag_phase) begin
			if (cfg.alt_phase_convention) begin
				phase_c = {1'b0, coord_t[0] ^ coord_x[0] ^ coord_y[0],
					coord_t[0] ^ coord_x[0], coord_t[0]};
			end else begin
				phase_c = {coord_x[0] ^ coord_y[0] ^ coord_z[0],
					coord_x[0] ^ coord_y[0], coord_x[0], 1'b0};
			end
		end
	end

	// canonical, staggered and heat-bath orderings each start from their own inner pair
	assign a1_c  = WK_W'(coord_z) + WK_W'(lz) * WK_W'(coord_t);
	assign b1_c  = WK_W'(coord_y) + WK_W'(ly) * WK_W'(coord_z);
	assign h1_c  = WK_W'(coord_x) + WK_W'(lx) * WK_W'(coord_t);
	assign vxy_c = (2*EW)'(lx) * (2*EW)'(ly);
	assign vzt_c = (2*EW)'(lz) * (2*EW)'(lt);
	assign ca1_c = CMP_W'(mat_col) + CMP_W'(nc) * CMP_W'(direction);
	assign cd1_c = CMP_W'(mat_row) + CMP_W'(nc) * CMP_W'(direction);

	logic [COORD_W-1:0] x_s1, y_s1, z_s1, t_s1;
	logic [DIR_W-1:0]   mu_s1, mun_s1;
	logic [ROW_W-1:0]   row_s1, col_s1;
	logic               r_s1, p_s1;
	logic [PHASE_W-1:0] phase_s1;
	logic [WK_W-1:0]    a1_s1, b1_s1, h1_s1;
	logic [2*EW-1:0]    vxy_s1, vzt_s1;
	logic [CMP_W-1:0]   ca1_s1, cd1_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			x_s1     <= coord_x;
			y_s1     <= coord_y;
			z_s1     <= coord_z;
			t_s1     <= coord_t;
			mu_s1    <= direction;
			mun_s1   <= mu_next;
			row_s1   <= mat_row;
			col_s1   <= mat_col;
			r_s1     <= imag_part;
			p_s1     <= par_c;
			phase_s1 <= phase_c;
			a1_s1    <= a1_c;
			b1_s1    <= b1_c;
			h1_s1    <= h1_c;
			vxy_s1   <= vxy_c;
			vzt_s1   <= vzt_c;
			ca1_s1   <= ca1_c;
			cd1_s1   <= cd1_c;
		end
	end

	// stage 2: middle horner terms, volume, component inner term by mode
	logic [WK_W-1:0]  a2_c, b2_c, h2_c, vol_c;
	logic [4*EW-1:0]  vol_full;
	logic [CMP_W-1:0] cm1, g_c;

	assign a2_c     = WK_W'(y_s1) + WK_W'(ly) * a1_s1;
	assign b2_c     = WK_W'(x_s1) + WK_W'(lx) * b1_s1;
	assign h2_c     = WK_W'(y_s1) + WK_W'(ly) * h1_s1;
	assign vol_full = (4*EW)'(vxy_s1) * (4*EW)'(vzt_s1);
	assign vol_c    = WK_W'(vol_full);
	assign cm1      = CMP_W'({mun_s1, r_s1});

	always_comb begin
		unique case (cfg.layout_mode) inside
			MODE_WILSON_GAUGE: g_c = CMP_W'(row_s1) + CMP_W'(nc) * ca1_s1;
			MODE_HEATBATH:     g_c = CMP_W'(row_s1) + CMP_W'(nc) * cm1;
			MODE_STAG_BLOCK:   g_c = CMP_W'(col_s1) + CMP_W'(nc) * CMP_W'(row_s1);
			MODE_WILSON_FERM, MODE_STAG_FERM: g_c = cd1_s1;
			default:           g_c = CMP_W'(col_s1) + CMP_W'(nc) * cd1_s1;
		endcase
	end

	logic [COORD_W-1:0] x_s2, z_s2, t_s2;
	logic [DIR_W-1:0]   mu_s2;
	logic [ROW_W-1:0]   col_s2;
	logic               r_s2, p_s2;
	logic [PHASE_W-1:0] phase_s2;
	logic [WK_W-1:0]    a2_s2, b2_s2, h2_s2, vol_s2;
	logic [CMP_W-1:0]   g_s2;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			x_s2     <= x_s1;
			z_s2     <= z_s1;
			t_s2     <= t_s1;
			mu_s2    <= mu_s1;
			col_s2   <= col_s1;
			r_s2     <= r_s1;
			p_s2     <= p_s1;
			phase_s2 <= phase_s1;
			a2_s2    <= a2_c;
			b2_s2    <= b2_c;
			h2_s2    <= h2_c;
			vol_s2   <= vol_c;
			g_s2     <= g_c;
		end
	end

	// stage 3: outer horner terms, direction offset, finished component
	logic [WK_W-1:0]    xa_prod, canon_c, canone_c, stag_c, hb_c, volmu_c;
	logic [COORD_W-1:0] x_even;
	logic [CMP_W-1:0]   comp_c;

	assign x_even   = {x_s2[COORD_W-1:1], 1'b0};
	assign xa_prod  = WK_W'(lx) * a2_s2;
	assign canon_c  = WK_W'(x_s2) + xa_prod;
	assign canone_c = WK_W'(x_even) + xa_prod;
	assign stag_c   = WK_W'(t_s2) + WK_W'(lt) * b2_s2;
	assign hb_c     = WK_W'(z_s2) + WK_W'(lz) * h2_s2;
	assign volmu_c  = vol_s2 * WK_W'(mu_s2);
	assign comp_c   = (cfg.layout_mode == MODE_HEATBATH)
		? CMP_W'(col_s2) + CMP_W'(nc) * g_s2
		: {g_s2[CMP_W-2:0], r_s2};

	logic               p_s3;
	logic [PHASE_W-1:0] phase_s3;
	logic [WK_W-1:0]    canon_s3, canone_s3, stag_s3, hb_s3, vol_s3, volmu_s3;
	logic [CMP_W-1:0]   comp_s3;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			p_s3      <= p_s2;
			phase_s3  <= phase_s2;
			canon_s3  <= canon_c;
			canone_s3 <= canone_c;
			stag_s3   <= stag_c;
			hb_s3     <= hb_c;
			vol_s3    <= vol_s2;
			volmu_s3  <= volmu_c;
			comp_s3   <= comp_c;
		end
	end

	// stage 4: checkerboard offset, halving and layout select
	logic [WK_W-1:0]    sum_even, sum_odd, sum_stag, blk_site, blk_link;
	logic [SITE_W-1:0]  site_nx;
	logic [LINK_W-1:0]  link_nx;
	logic [COMP_W-1:0]  comp_nx;
	logic               absent_nx, nomove_nx;

	assign sum_even = canone_s3 + (p_s3 ? vol_s3 : '0);
	assign sum_odd  = canone_s3 + (p_s3 ? '0 : vol_s3);
	assign sum_stag = stag_s3 + (p_s3 ? vol_s3 : '0);
	assign blk_site = (stag_s3 >> 1) + (p_s3 ? (vol_s3 >> 1) : '0);
	assign blk_link = blk_site + volmu_s3;

	always_comb begin
		site_nx   = canon_s3[SITE_W-1:0];
		link_nx   = '0;
		comp_nx   = comp_s3[COMP_W-1:0];
		absent_nx = 1'b0;
		nomove_nx = 1'b0;
		unique case (cfg.layout_mode)
			MODE_WILSON_GAUGE: site_nx = sum_even[SITE_W:1];
			MODE_HEATBATH:     site_nx = hb_s3[SITE_W-1:0];
			MODE_STAG_BLOCK: begin
				site_nx = blk_site[SITE_W-1:0];
				link_nx = blk_link[LINK_W-1:0];
			end
			MODE_WILSON_FERM: begin
				if (cfg.half_lattice) begin
					site_nx   = canone_s3[SITE_W:1];
					nomove_nx = 1'b1;
				end else begin
					site_nx = sum_odd[SITE_W:1];
				end
			end
			MODE_STAG_FERM: begin
				if (!cfg.half_lattice) begin
					site_nx = sum_stag[SITE_W:1];
				end else if (p_s3) begin
					// odd site is not stored in a one-checkerboard field
					site_nx   = '0;
					comp_nx   = '0;
					absent_nx = 1'b1;
				end else begin
					site_nx = stag_s3[SITE_W:1];
				end
			end
			default: nomove_nx = 1'b1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			dest_site      <= site_nx;
			dest_link      <= link_nx;
			dest_component <= comp_nx;
			phase_bits     <= phase_s3;
			site_absent    <= absent_nx;
			no_move        <= nomove_nx;
		end
	end

	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && site_absent |->
			dest_site == '0 && dest_link == '0 && dest_component == '0)
		else $error("absent site carries a nonzero index");

	a_link_moved: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dest_link != '0 |-> !no_move && !site_absent)
		else $error("link index on an unmoved or absent site");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_move |-> !site_absent)
		else $error("site both absent and unmoved");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && v3_s3 |=> out_valid)
		else $error("stage 3 item lost on output transfer");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v1_s1)
		else $error("input transfer did not reach stage 1");

endmodule
